// ===== design/wdt_pkg.sv =====
`default_nettype none

package wdt_pkg;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ALWAYS_ON    = 2'd0,
        REG_SYS_PRESCALE = 2'd1
    } cfg_reg_t;

    localparam int CFG_DATA_W = 8;

    // control byte layout
    localparam int CTL_W     = 8;
    localparam int SEL_W     = 3;
    localparam int EN_POS    = 3;
    localparam int CE_POS    = 4;

    // timed change window
    localparam int WIN_W = 3;
    localparam logic [WIN_W-1:0] WINDOW_TICKS = 3'd4;

    // counters
    localparam int FAST_W = 8;
    localparam int SLOW_W = 22;
    localparam logic [SLOW_W-1:0] BASE_TIMEOUT = 22'(16 * 1024);
    localparam logic [SLOW_W-1:0] MAX_TIMEOUT  = 22'(2048 * 1024);

    localparam logic [FAST_W-1:0] SYS_PRESCALE_RESET = 8'd1;

endpackage : wdt_pkg

`default_nettype wire

// ===== design/watchdog_timer_with_timed_sequence.sv =====
`default_nettype none

// watchdog timer with a timed change sequence. one input beat is one system
// tick carrying the control byte (bits 2..0 prescale select, bit 3 enable,
// bit 4 change enable) and a flag for a software write in that tick; each
// beat yields exactly one result beat (timeout pulse, clear-change-enable
// request, running flag). a beat is accepted whenever the input is ready: the whole tick is
// evaluated combinationally from the input and the state registers, and the
// result lands in an output register in the next cycle, so the input side keeps
// accepting while the result register drains. throughput is one beat per
// clock unless stalled; the only limit is the output register, which
// stalls the input only while a result is held and not taken. the timeout is
// (sys_prescale + 1) system ticks per oscillator tick times
// (16K << prescale select) + 1 oscillator ticks. configuration writes are
// taken in any cycle and must only be issued while no result is pending.
module watchdog_timer_with_timed_sequence
    import wdt_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    // configuration write port
    input  wire logic                   cfg_write_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,

    // tick input channel
    input  wire logic                   item_valid,
    output logic                        item_ready,
    input  wire logic [CTL_W-1:0]       control_value,
    input  wire logic                   control_written,

    // result channel
    output logic                        result_valid,
    input  wire logic                   result_ready,
    output logic                        watchdog_reset,
    output logic                        clear_change_enable,
    output logic                        running
);

    // configuration registers
    logic                    always_on_reg;
    logic [FAST_W-1:0]       sys_prescale_reg;

    // watchdog state
    logic                    enabled_reg,      enabled_next;
    logic [WIN_W-1:0]        window_left_reg,  window_left_next;
    logic [FAST_W-1:0]       fast_count_reg,   fast_count_next;
    logic [SLOW_W-1:0]       slow_count_reg,   slow_count_next;
    logic [SEL_W-1:0]        sel_reg,          sel_next;
    logic [CTL_W-1:0]        prev_ctl_reg,     prev_ctl_next;

    // result register
    logic                    result_valid_reg;
    logic                    wdreset_reg,      wdreset_next;
    logic                    clear_ce_reg,     clear_ce_next;
    logic                    running_reg,      running_next;

    logic                    accept;
    logic [SLOW_W-1:0]       limit;

    // input is free whenever the result register is empty or draining
    assign item_ready = !result_valid_reg || result_ready;
    assign accept     = item_valid && item_ready;

    // one system tick, in order: start check, window check, window open, count, remember byte
    always_comb
    begin
        logic en;
        logic ce;

        en = control_value[EN_POS];
        ce = control_value[CE_POS];

        enabled_next     = enabled_reg;
        window_left_next = window_left_reg;
        fast_count_next  = fast_count_reg;
        slow_count_next  = slow_count_reg;
        sel_next         = sel_reg;
        wdreset_next     = 1'b0;
        clear_ce_next    = 1'b0;

        // start on a change of the byte that sets enable
        if (!always_on_reg && !enabled_reg && (control_value != prev_ctl_reg) && en)
        begin
            enabled_next    = 1'b1;
            fast_count_next = '0;
            slow_count_next = '0;
        end

        // open window: change-enable seen clear applies the new setting
        if (window_left_reg != '0)
        begin
            if (!ce)
            begin
                if (!en)
                begin
                    enabled_next    = 1'b0;
                    fast_count_next = '0;
                    slow_count_next = '0;
                end
                sel_next         = control_value[SEL_W-1:0];
                window_left_next = '0;
            end
            else
            begin
                window_left_next = window_left_reg - 1'b1;
                if (window_left_next == '0)
                begin
                    clear_ce_next = 1'b1;
                end
            end
        end

        // a write with change-enable and enable opens a new window
        if (control_written && ce && en)
        begin
            window_left_next = WINDOW_TICKS;
        end

        // prescaled counting toward the timeout
        limit = BASE_TIMEOUT << sel_next;
        if (always_on_reg || enabled_next)
        begin
            if (fast_count_next < sys_prescale_reg)
            begin
                fast_count_next = fast_count_next + 1'b1;
            end
            else
            begin
                if (slow_count_next < limit)
                begin
                    slow_count_next = slow_count_next + 1'b1;
                end
                else
                begin
                    wdreset_next    = 1'b1;
                    slow_count_next = '0;
                    enabled_next    = 1'b0;
                end
                fast_count_next = '0;
            end
        end

        // remember the byte, with change-enable dropped when the window expired
        prev_ctl_next = control_value;
        if (clear_ce_next)
        begin
            prev_ctl_next[CE_POS] = 1'b0;
        end

        running_next = always_on_reg || enabled_next;
    end

    // state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            always_on_reg    <= 1'b0;
            sys_prescale_reg <= SYS_PRESCALE_RESET;
            enabled_reg      <= 1'b0;
            window_left_reg  <= '0;
            fast_count_reg   <= '0;
            slow_count_reg   <= '0;
            sel_reg          <= '0;
            prev_ctl_reg     <= '0;
        end
        else
        begin
            if (accept)
            begin
                window_left_reg <= window_left_next;
                fast_count_reg  <= fast_count_next;
                slow_count_reg  <= slow_count_next;
                sel_reg         <= sel_next;
                prev_ctl_reg    <= prev_ctl_next;
            end
            // fuse write also forces the enable state
            if (cfg_write_en && (cfg_index == REG_ALWAYS_ON))
            begin
                enabled_reg <= cfg_data[0];
            end
            else if (accept)
            begin
                enabled_reg <= enabled_next;
            end
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_ALWAYS_ON:
                    begin
                        always_on_reg <= cfg_data[0];
                    end
                    REG_SYS_PRESCALE:
                    begin
                        sys_prescale_reg <= cfg_data;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            result_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            wdreset_reg  <= wdreset_next;
            clear_ce_reg <= clear_ce_next;
            running_reg  <= running_next;
        end
    end

    assign result_valid        = result_valid_reg;
    assign watchdog_reset      = wdreset_reg;
    assign clear_change_enable = clear_ce_reg;
    assign running             = running_reg;

    // window never reloads past its length
    assert property (@(posedge clk) disable iff (!rst_n)
        window_left_reg <= WINDOW_TICKS)
    else $error("window counter out of range");

    // slow count never passes the longest timeout
    assert property (@(posedge clk) disable iff (!rst_n)
        slow_count_reg <= MAX_TIMEOUT)
    else $error("slow count out of range");

    // every accepted tick produces a result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> result_valid_reg)
    else $error("accepted tick lost its result");

    // a timeout stops the watchdog unless the fuse holds it on
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && wdreset_next && !always_on_reg |=> !running_reg && !enabled_reg)
    else $error("watchdog still running after timeout");

endmodule : watchdog_timer_with_timed_sequence

`default_nettype wire
